>>> sv/bts_pkg.sv
`default_nettype none

package bts_pkg;

    // shard counts and field widths
    localparam int MAX_SHARDS = 1024;
    localparam int CNT_W      = 11;
    localparam int IDX_W      = 10;
    localparam int ACT_W      = 3;
    localparam int PROD_W     = IDX_W + CNT_W;

    // shared divider
    localparam int DIV_W     = 11;
    localparam int DIV_CNT_W = 4;

    localparam logic [CNT_W-1:0] MAX_COUNT = CNT_W'(MAX_SHARDS);

    // configuration register indexes
    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] CFG_NUM_SRC = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_NUM_DST = 1'b1;

    // action codes
    localparam logic [ACT_W-1:0] ACT_NONE       = 3'd0;
    localparam logic [ACT_W-1:0] ACT_SEND_ROOT  = 3'd1;
    localparam logic [ACT_W-1:0] ACT_RECV_SRC   = 3'd2;
    localparam logic [ACT_W-1:0] ACT_RECV_PEER  = 3'd3;
    localparam logic [ACT_W-1:0] ACT_SEND_CHILD = 3'd4;

    typedef struct packed {
        logic             src_present;
        logic [IDX_W-1:0] src_index;
        logic             dst_present;
        logic [IDX_W-1:0] dst_index;
    } t_bts_in;

    typedef struct packed {
        logic [ACT_W-1:0] action;
        logic [IDX_W-1:0] peer_shard;
        logic             last;
    } t_bts_out;

    typedef enum logic [1:0] {
        EMIT_NONE,
        EMIT_ROOT,
        EMIT_RECV,
        EMIT_CHILD
    } t_emit_sel;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_PER_GO,
        ST_PER_WAIT,
        ST_Q_GO,
        ST_Q_WAIT,
        ST_DECIDE,
        ST_NONE,
        ST_ROOT,
        ST_RECV,
        ST_CHILD
    } t_bts_state;

    typedef struct packed {
        logic      load_in;
        logic      div_start;
        logic      div_sel_q;
        logic      per_load;
        logic      part_load;
        logic      prep_load;
        logic      out_load;
        t_emit_sel out_sel;
        logic      out_last;
        logic      size_shift;
    } t_bts_cmd;

    typedef struct packed {
        logic div_busy;
        logic extra;
        logic root_en;
        logic dst_en;
        logic has_child;
        logic child_ok;
        logic size_one;
        logic out_free;
    } t_bts_sts;

endpackage

`default_nettype wire

>>> sv/bts_divider.sv
`default_nettype none

module bts_divider import bts_pkg::*; (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_start,
    input  wire logic [DIV_W-1:0] i_dividend,
    input  wire logic [DIV_W-1:0] i_divisor,
    output logic                  o_busy,
    output logic [DIV_W-1:0]      o_quotient,
    output logic [DIV_W-1:0]      o_remainder
);

    logic [DIV_CNT_W-1:0] r_cnt;
    logic [DIV_W-1:0]     r_rem;
    logic [DIV_W-1:0]     r_quo;
    logic [DIV_W-1:0]     r_dvs;

    logic [DIV_W:0]       w_shift;
    logic [DIV_W:0]       w_diff;
    logic                 w_fits;

    // restoring step, one quotient bit per cycle
    assign w_shift = {r_rem, r_quo[DIV_W-1]};
    assign w_fits  = w_shift >= {1'b0, r_dvs};
    assign w_diff  = w_shift - {1'b0, r_dvs};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_start) begin
            r_cnt <= DIV_CNT_W'(DIV_W);
        end else if (r_cnt != '0) begin
            r_cnt <= r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_quo <= i_dividend;
            r_dvs <= i_divisor;
        end else if (r_cnt != '0) begin
            r_rem <= w_fits ? w_diff[DIV_W-1:0] : w_shift[DIV_W-1:0];
            r_quo <= {r_quo[DIV_W-2:0], w_fits};
        end
    end

    assign o_busy      = (r_cnt != '0);
    assign o_quotient  = r_quo;
    assign o_remainder = r_rem;

endmodule

`default_nettype wire

>>> sv/bts_datapath.sv
`default_nettype none

module bts_datapath import bts_pkg::*; (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  wire logic [CNT_W-1:0]     i_cfg_data,
    input  wire t_bts_in              i_in_data,
    input  wire logic                 i_out_stall,
    output logic                      o_out_valid,
    output t_bts_out                  o_out_data,
    input  wire t_bts_cmd             i_cmd,
    output t_bts_sts                  o_sts
);

    function automatic logic [CNT_W-1:0] clamp_count(input logic [CNT_W-1:0] v);
        logic [CNT_W-1:0] res;
        res = v;
        if (v == '0) res = CNT_W'(1);
        else if (v > MAX_COUNT) res = MAX_COUNT;
        return res;
    endfunction

    logic [CNT_W-1:0]  r_num_src;
    logic [CNT_W-1:0]  r_num_dst;
    t_bts_in           r_in;
    logic [CNT_W-1:0]  r_per;
    logic [PROD_W-1:0] r_partner;
    logic              r_root_en;
    logic              r_extra;
    logic              r_dst_en;
    logic              r_has_child;
    logic [CNT_W-1:0]  r_n;
    logic [IDX_W-1:0]  r_r;
    logic [IDX_W-1:0]  r_size;
    logic [ACT_W-1:0]  r_recv_act;
    logic [IDX_W-1:0]  r_recv_peer;
    logic              r_out_valid;
    t_bts_out          r_out;

    logic [CNT_W-1:0]  w_s;
    logic [CNT_W-1:0]  w_d;
    logic [CNT_W:0]    w_sum;
    logic [DIV_W-1:0]  w_dvd;
    logic [DIV_W-1:0]  w_dvs;
    logic              w_div_busy;
    logic [DIV_W-1:0]  w_quo;
    logic [DIV_W-1:0]  w_rem;
    logic [IDX_W-1:0]  w_r;
    logic [IDX_W-1:0]  w_t;
    logic [CNT_W-1:0]  w_left;
    logic [CNT_W-1:0]  w_n;
    logic [CNT_W-1:0]  w_m;
    logic [CNT_W-1:0]  w_pw;
    logic [IDX_W-1:0]  w_low;
    logic [IDX_W-1:0]  w_size;
    logic [ACT_W-1:0]  w_recv_act;
    logic [IDX_W-1:0]  w_recv_peer;
    logic              w_part_lt;
    logic              w_has_child;
    logic              w_dst_en;
    logic              w_out_free;
    t_bts_out          w_out;

    assign w_s = clamp_count(r_num_src);
    assign w_d = clamp_count(r_num_dst);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_num_src <= CNT_W'(1);
            r_num_dst <= CNT_W'(1);
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_NUM_SRC: r_num_src <= i_cfg_data;
                CFG_NUM_DST: r_num_dst <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // leaves per source: ceil(d / s), then the group of the destination
    assign w_sum = {1'b0, w_d} + {1'b0, w_s} - 1'b1;
    assign w_dvd = i_cmd.div_sel_q ? DIV_W'(r_in.dst_index) : w_sum[DIV_W-1:0];
    assign w_dvs = i_cmd.div_sel_q ? r_per : w_s;

    bts_divider u_div (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (i_cmd.div_start),
        .i_dividend  (w_dvd),
        .i_divisor   (w_dvs),
        .o_busy      (w_div_busy),
        .o_quotient  (w_quo),
        .o_remainder (w_rem)
    );

    // rank, group size and first subtree size
    always_comb begin
        w_r    = w_rem[IDX_W-1:0];
        w_t    = r_in.dst_index - w_r;
        w_left = w_d - {1'b0, w_t};
        w_n    = (w_left > r_per) ? r_per : w_left;
        w_m    = w_n - 1'b1;
        w_m    = w_m | (w_m >> 1);
        w_m    = w_m | (w_m >> 2);
        w_m    = w_m | (w_m >> 4);
        w_m    = w_m | (w_m >> 8);
        w_pw   = w_m + 1'b1;
        w_low  = w_r & (~w_r + 1'b1);
        if (w_r == '0) begin
            w_size      = w_pw[IDX_W:1];
            w_recv_act  = ACT_RECV_SRC;
            w_recv_peer = w_quo[IDX_W-1:0];
        end else if (w_r[0]) begin
            w_size      = '0;
            w_recv_act  = ACT_RECV_PEER;
            w_recv_peer = r_in.dst_index - 1'b1;
        end else begin
            w_size      = w_low >> 1;
            w_recv_act  = ACT_RECV_PEER;
            w_recv_peer = r_in.dst_index - w_low;
        end
        w_has_child = !w_r[0] && (({1'b0, w_r} + 1'b1) < w_n);
        w_dst_en    = r_in.dst_present && ({1'b0, r_in.dst_index} < w_d);
        w_part_lt   = r_partner < PROD_W'(w_d);
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in)   r_in      <= i_in_data;
        if (i_cmd.per_load)  r_per     <= w_quo;
        if (i_cmd.part_load) r_partner <= PROD_W'(r_in.src_index) * PROD_W'(r_per);
        if (i_cmd.prep_load) begin
            r_root_en   <= r_in.src_present && w_part_lt;
            r_extra     <= r_in.src_present && !w_part_lt;
            r_dst_en    <= w_dst_en;
            r_has_child <= w_has_child;
            r_n         <= w_n;
            r_r         <= w_r;
            r_recv_act  <= w_recv_act;
            r_recv_peer <= w_recv_peer;
        end
        if (i_cmd.prep_load)       r_size <= w_size;
        else if (i_cmd.size_shift) r_size <= r_size >> 1;
    end

    // result register
    assign w_out_free = !r_out_valid || !i_out_stall;

    always_comb begin
        w_out.last = i_cmd.out_last;
        case (i_cmd.out_sel)
            EMIT_NONE: begin
                w_out.action     = ACT_NONE;
                w_out.peer_shard = '0;
            end
            EMIT_ROOT: begin
                w_out.action     = ACT_SEND_ROOT;
                w_out.peer_shard = r_partner[IDX_W-1:0];
            end
            EMIT_RECV: begin
                w_out.action     = r_recv_act;
                w_out.peer_shard = r_recv_peer;
            end
            EMIT_CHILD: begin
                w_out.action     = ACT_SEND_CHILD;
                w_out.peer_shard = r_in.dst_index + r_size;
            end
            default: begin
                w_out.action     = ACT_NONE;
                w_out.peer_shard = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) r_out <= w_out;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    always_comb begin
        o_sts.div_busy  = w_div_busy;
        o_sts.extra     = r_extra;
        o_sts.root_en   = r_root_en;
        o_sts.dst_en    = r_dst_en;
        o_sts.has_child = r_has_child;
        o_sts.child_ok  = ({2'b0, r_r} + {2'b0, r_size}) < {1'b0, r_n};
        o_sts.size_one  = (r_size == IDX_W'(1));
        o_sts.out_free  = w_out_free;
    end

endmodule

`default_nettype wire

>>> sv/bts_ctrl.sv
`default_nettype none

module bts_ctrl import bts_pkg::*; (
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_in_valid,
    output logic          o_in_stall,
    input  wire t_bts_sts i_sts,
    output t_bts_cmd      o_cmd
);

    t_bts_state r_state;
    t_bts_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE:     if (i_in_valid) n_state = ST_PER_GO;
            ST_PER_GO:   n_state = ST_PER_WAIT;
            ST_PER_WAIT: if (!i_sts.div_busy) n_state = ST_Q_GO;
            ST_Q_GO:     n_state = ST_Q_WAIT;
            ST_Q_WAIT:   if (!i_sts.div_busy) n_state = ST_DECIDE;
            ST_DECIDE: begin
                if (i_sts.extra || (!i_sts.root_en && !i_sts.dst_en)) n_state = ST_NONE;
                else if (i_sts.root_en) n_state = ST_ROOT;
                else n_state = ST_RECV;
            end
            ST_NONE:     if (i_sts.out_free) n_state = ST_IDLE;
            ST_ROOT: begin
                if (i_sts.out_free) n_state = i_sts.dst_en ? ST_RECV : ST_IDLE;
            end
            ST_RECV: begin
                if (i_sts.out_free) n_state = i_sts.has_child ? ST_CHILD : ST_IDLE;
            end
            ST_CHILD: begin
                if ((!i_sts.child_ok || i_sts.out_free) && i_sts.size_one) n_state = ST_IDLE;
            end
            default:     n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_cmd         = '0;
        o_cmd.out_sel = EMIT_NONE;
        o_in_stall    = (r_state != ST_IDLE);
        case (r_state)
            ST_IDLE:     o_cmd.load_in = i_in_valid;
            ST_PER_GO:   o_cmd.div_start = 1'b1;
            ST_PER_WAIT: o_cmd.per_load = !i_sts.div_busy;
            ST_Q_GO: begin
                o_cmd.div_start = 1'b1;
                o_cmd.div_sel_q = 1'b1;
                o_cmd.part_load = 1'b1;
            end
            ST_Q_WAIT: begin
                o_cmd.div_sel_q = 1'b1;
                o_cmd.prep_load = !i_sts.div_busy;
            end
            ST_DECIDE: ;
            ST_NONE: begin
                o_cmd.out_load = i_sts.out_free;
                o_cmd.out_sel  = EMIT_NONE;
                o_cmd.out_last = 1'b1;
            end
            ST_ROOT: begin
                o_cmd.out_load = i_sts.out_free;
                o_cmd.out_sel  = EMIT_ROOT;
                o_cmd.out_last = !i_sts.dst_en;
            end
            ST_RECV: begin
                o_cmd.out_load = i_sts.out_free;
                o_cmd.out_sel  = EMIT_RECV;
                o_cmd.out_last = !i_sts.has_child;
            end
            ST_CHILD: begin
                o_cmd.out_load   = i_sts.child_ok && i_sts.out_free;
                o_cmd.out_sel    = EMIT_CHILD;
                o_cmd.out_last   = i_sts.size_one;
                o_cmd.size_shift = !i_sts.child_ok || i_sts.out_free;
            end
            default: ;
        endcase
    end

`ifndef SYNTHESIS
    a_load_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.out_load |-> i_sts.out_free)
        else $error("result loaded while output register is held");
    a_div_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.div_start |=> i_sts.div_busy)
        else $error("divider did not start");
    a_idle_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_IDLE) |-> !i_sts.div_busy)
        else $error("divider busy while idle");
`endif

endmodule

`default_nettype wire

>>> sv/broadcast_tree_schedule_top.sv
// sequence: an accepted transaction goes through two 11-step passes of the shared
//   radix-2 divider, then the result states; a new transaction is taken only once
//   the last result of the previous one has been loaded into the output register
// reset: i_rst_n synchronous active low, clears control state and output valid,
//   sets both shard counts to 1
`default_nettype none

module broadcast_tree_schedule_top import bts_pkg::*; (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    // configuration write port
    input  wire logic                 i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  wire logic [CNT_W-1:0]     i_cfg_data,
    // request channel
    input  wire logic                 i_in_valid,
    output logic                      o_in_stall,
    input  wire t_bts_in              i_in_data,
    // result channel
    output logic                      o_out_valid,
    input  wire logic                 i_out_stall,
    output t_bts_out                  o_out_data
);

    // controller sequences one transaction at a time:
    //   leaves per source = ceil(d / s) on the divider
    //   partner multiply in the datapath, group/rank division on the same divider
    //   prep registers rank, group size and first subtree size
    //   results go out through a single output register, one per cycle while not
    //   stalled, so a new transaction is taken while the last result still waits
    t_bts_cmd w_cmd;
    t_bts_sts w_sts;

    bts_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd)
    );

    // datapath holds config, divider, tree walk and the result register
    bts_datapath u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .i_in_data   (i_in_data),
        .i_out_stall (i_out_stall),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data),
        .i_cmd       (w_cmd),
        .o_sts       (w_sts)
    );

endmodule

`default_nettype wire

>>> dv/tb_broadcast_tree_schedule_top.sv
`default_nettype none

module tb_broadcast_tree_schedule_top;
    import bts_pkg::*;

    localparam int REQ_GAP_MAX = 11;
    localparam int RES_GAP_MAX = 11;
    localparam int LONG_HOLD   = 400;
    localparam int DRAIN_WAIT  = 60;
    localparam int SCHED_CAP   = 12;
    localparam int RAND_PHASES = 6;
    localparam int RAND_ITEMS  = 17;

    // dut inputs, all known from time zero
    logic                 i_clk       = 1'b0;
    logic                 i_rst_n     = 1'b0;
    logic                 i_cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_idx   = CFG_NUM_SRC;
    logic [CNT_W-1:0]     i_cfg_data  = '0;
    logic                 i_in_valid  = 1'b0;
    logic                 o_in_stall;
    t_bts_in              i_in_data   = '0;
    logic                 o_out_valid;
    logic                 i_out_stall = 1'b0;
    t_bts_out             o_out_data;

    broadcast_tree_schedule_top DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );

    // shadow copy of the two shard-count registers
    logic [CNT_W-1:0] num_src = 11'd1;
    logic [CNT_W-1:0] num_dst = 11'd1;

    t_bts_in  request_q[$];   // requests waiting to be offered
    t_bts_out sched_q[$];     // schedule entries still owed by the block
    t_bts_out step_q[$];      // scratch list for one request

    int  n_requests = 0;
    int  n_results  = 0;
    int  n_settings = 0;
    int  n_errors   = 0;

    // handshake flags, set at the rising edge and consumed at the falling edge
    bit  req_taken = 1'b0;
    bit  res_taken = 1'b0;
    int  req_wait  = 0;
    int  res_wait  = 0;
    int  req_gap_max = 0;
    int  res_gap_max = 0;
    bit  result_hold = 1'b0;

    initial begin
        forever #1 i_clk = ~i_clk;
    end

    // hard stop in case the block hangs
    initial begin
        #500000;
        $display("tb_broadcast_tree_schedule_top failed");
        $finish;
    end

    function automatic int clamp_count(logic [CNT_W-1:0] v);
        if (v < 1) return 1;
        if (v > MAX_COUNT) return MAX_SHARDS;
        return int'(v);
    endfunction

    function automatic void add_step(logic [ACT_W-1:0] act, int peer);
        t_bts_out one;
        // anything past the twelfth entry is dropped
        if (step_q.size() >= SCHED_CAP) return;
        one.action     = act;
        one.peer_shard = IDX_W'(peer);
        one.last       = 1'b0;
        step_q = {step_q, one};
    endfunction

    // expected transfers for one request under the current shard counts
    function automatic void build_schedule(t_bts_in req);
        int s, d, per, partner, q, t, r, n, pw, start, size, nxt, guard;
        bit extra;
        t_bts_out one;
        s = clamp_count(num_src);
        d = clamp_count(num_dst);
        per = (d + s - 1) / s;
        extra = 1'b0;
        step_q.delete();

        if (req.src_present) begin
            partner = int'(req.src_index) * per;
            // a source with no group of its own does nothing at all
            extra = (partner >= d);
            if (!extra) add_step(ACT_SEND_ROOT, partner);
        end

        // a destination index past the last shard counts as absent
        if (!extra && req.dst_present && int'(req.dst_index) < d) begin
            q = int'(req.dst_index) / per;
            t = q * per;
            r = int'(req.dst_index) - t;
            n = d - t;
            if (n > per) n = per;

            if (r == 0) add_step(ACT_RECV_SRC, q);
            else if (r % 2 == 1) add_step(ACT_RECV_PEER, t + r - 1);

            if (r % 2 == 0) begin
                pw = 1;
                while (pw < n) pw = pw * 2;
                size  = pw;
                start = 0;
                // binary search down the tree to find this rank's subtree
                for (guard = 0; guard < 40 && start != r && size > 0; guard++) begin
                    size = size / 2;
                    if (r > start) start = start + size;
                    else start = start - size;
                end
                if (r != 0) add_step(ACT_RECV_PEER, t + r - size);
                size = size / 2;
                nxt  = start + size;
                // children past the group end are skipped, the walk goes on
                while (size > 0) begin
                    if (nxt < n) add_step(ACT_SEND_CHILD, t + nxt);
                    size = size / 2;
                    nxt  = nxt - size;
                end
            end
        end

        if (step_q.size() == 0) begin
            one = '0;
            one.action = ACT_NONE;
            step_q = {step_q, one};
        end
        step_q[step_q.size()-1].last = 1'b1;
        sched_q = {sched_q, step_q};
    endfunction

    task automatic report_mismatch(input string msg);
        $display("mismatch @%0t: %s", $time, msg);
        n_errors++;
    endtask

    // request driver: a new transaction goes out after its drawn gap
    always @(negedge i_clk) begin : drive_requests
        logic    nxt_valid;
        t_bts_in nxt_data;
        nxt_valid = i_in_valid;
        nxt_data  = i_in_data;
        if (req_taken) begin
            req_taken = 1'b0;
            nxt_valid = 1'b0;
            req_wait  = $urandom_range(0, req_gap_max);
        end
        if (i_rst_n && !nxt_valid && request_q.size() > 0) begin
            if (req_wait > 0) begin
                req_wait--;
            end else begin
                nxt_valid = 1'b1;
                nxt_data  = request_q[0];
            end
        end
        i_in_valid <= nxt_valid;
        i_in_data  <= nxt_data;
    end

    // result side: per-result stall, plus the long hold when asked
    always @(negedge i_clk) begin
        if (res_taken) begin
            res_taken = 1'b0;
            res_wait  = $urandom_range(0, res_gap_max);
        end else if (res_wait > 0) begin
            res_wait--;
        end
        i_out_stall <= result_hold || (res_wait != 0);
    end

    // monitor: check results first, then book the new request
    always @(posedge i_clk) begin : watch_ports
        t_bts_out want;
        if (i_rst_n) begin
            if (o_out_valid && !i_out_stall) begin
                res_taken = 1'b1;
                n_results++;
                if (sched_q.size() == 0) begin
                    report_mismatch($sformatf("unexpected result act=%0d peer=%0d last=%0b",
                        o_out_data.action, o_out_data.peer_shard, o_out_data.last));
                end else begin
                    want = sched_q.pop_front();
                    if (o_out_data.action !== want.action)
                        report_mismatch($sformatf("action %0d, want %0d",
                            o_out_data.action, want.action));
                    if (o_out_data.peer_shard !== want.peer_shard)
                        report_mismatch($sformatf("peer_shard %0d, want %0d",
                            o_out_data.peer_shard, want.peer_shard));
                    if (o_out_data.last !== want.last)
                        report_mismatch($sformatf("last %0b, want %0b",
                            o_out_data.last, want.last));
                end
            end
            if (i_in_valid && !o_in_stall) begin
                req_taken = 1'b1;
                n_requests++;
                build_schedule(i_in_data);
                if (request_q.size() > 0) void'(request_q.pop_front());
            end
        end
    end

    // register writes happen only with nothing in flight
    task automatic write_count(input logic [CFG_IDX_W-1:0] idx, input logic [CNT_W-1:0] value);
        @(negedge i_clk);
        i_cfg_we   = 1'b1;
        i_cfg_idx  = idx;
        i_cfg_data = value;
        if (idx == CFG_NUM_SRC) num_src = value;
        else num_dst = value;
        @(negedge i_clk);
        i_cfg_we = 1'b0;
    endtask

    task automatic set_counts(input int s, input int d);
        write_count(CFG_NUM_SRC, CNT_W'(s));
        write_count(CFG_NUM_DST, CNT_W'(d));
        n_settings++;
    endtask

    task automatic queue_request(input bit sp, input int si, input bit dp, input int di);
        t_bts_in req;
        req.src_present = sp;
        req.src_index   = IDX_W'(si);
        req.dst_present = dp;
        req.dst_index   = IDX_W'(di);
        request_q = {request_q, req};
    endtask

    // sender pauses here until every owed result has come back
    task automatic wait_drained();
        while (request_q.size() != 0 || sched_q.size() != 0) @(posedge i_clk);
    endtask

    // mostly well-formed: valid source ranks and in-range destinations
    function automatic t_bts_in rand_request();
        t_bts_in req;
        int s, d, per, roots;
        s = clamp_count(num_src);
        d = clamp_count(num_dst);
        per   = (d + s - 1) / s;
        roots = (d + per - 1) / per;
        if ($urandom_range(0, 7) == 0) begin
            req = $bits(t_bts_in)'($urandom());
        end else begin
            req.src_present = 1'($urandom_range(0, 1));
            // occasionally one rank past the last group, an extra source
            req.src_index   = IDX_W'($urandom_range(0, roots < MAX_SHARDS ? roots : roots - 1));
            req.dst_present = ($urandom_range(0, 3) != 0);
            req.dst_index   = IDX_W'($urandom_range(0, d - 1));
        end
        return req;
    endfunction

    initial begin
        int s, d;
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // reset counts: one source, one destination
        req_gap_max = 0;
        res_gap_max = 0;
        queue_request(1, 0, 1, 0);
        queue_request(0, 0, 0, 0);
        queue_request(1, 1023, 0, 0);
        queue_request(0, 0, 1, 1023);
        wait_drained();

        // zero source count clamps to one, one group of 1024: deepest tree
        set_counts(0, 1024);
        queue_request(1, 0, 1, 0);
        queue_request(0, 0, 1, 1023);
        queue_request(0, 0, 1, 512);
        queue_request(1, 1, 1, 5);
        queue_request(0, 0, 1, 6);
        wait_drained();

        // both counts above the maximum clamp to 1024, single-shard groups
        req_gap_max = REQ_GAP_MAX;
        res_gap_max = RES_GAP_MAX;
        set_counts(2047, 2047);
        queue_request(1, 1023, 1, 1023);
        queue_request(1, 682, 0, 341);
        wait_drained();

        // uneven groups of three, children past the group end
        set_counts(3, 7);
        queue_request(0, 0, 1, 2);
        queue_request(0, 0, 1, 5);
        queue_request(1, 2, 1, 6);
        queue_request(1, 3, 1, 0);
        queue_request(0, 0, 1, 3);
        wait_drained();

        // many sources onto a single destination
        set_counts(1024, 1);
        queue_request(1, 0, 1, 0);
        queue_request(1, 1, 0, 0);
        queue_request(0, 0, 1, 1);
        wait_drained();

        for (int p = 0; p < RAND_PHASES; p++) begin
            s = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 2047) : $urandom_range(1, 24);
            d = ($urandom_range(0, 2) == 0) ? $urandom_range(0, 2047) : $urandom_range(1, 64);
            set_counts(s, d);
            req_gap_max = (p % 2 == 0) ? REQ_GAP_MAX : 0;
            res_gap_max = (p % 3 == 2) ? 0 : RES_GAP_MAX;
            if (p == 1) begin
                // receiver holds off while requests keep coming, block backs up
                fork
                    begin
                        result_hold = 1'b1;
                        repeat (LONG_HOLD) @(posedge i_clk);
                        result_hold = 1'b0;
                    end
                join_none
            end
            for (int k = 0; k < RAND_ITEMS; k++) request_q = {request_q, rand_request()};
            wait_drained();
        end

        // give any stray result time to show up
        repeat (DRAIN_WAIT) @(posedge i_clk);

        $display("run covered %0d requests over %0d shard-count settings", n_requests, n_settings);
        $display("checked %0d schedule entries, %0d mismatches", n_results, n_errors);
        if (n_errors == 0 && sched_q.size() == 0) begin
            $display("tb_broadcast_tree_schedule_top passed");
        end else begin
            $display("tb_broadcast_tree_schedule_top failed");
        end
        $finish;
    end

endmodule

`default_nettype wire
